FILE: hdl/fmt_pkg.sv
package fmt_pkg;

  localparam int unsigned MAX_LOGICAL_DEF      = 4096;
  localparam int unsigned MAX_DESTINATIONS_DEF = 8192;
  localparam int unsigned MAX_FANOUT_DEF       = 64;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LI_W     = 12;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned PHYS_W   = 16;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned LC_W     = 13;
  localparam int unsigned TD_W     = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned OFF_W    = 19;
  localparam int unsigned SLOT_W   = 20;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE  = 2'd0,
    FUNC_CLOSE  = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOGICAL_COUNT = 1'b0,
    CFG_TOTAL_DEST    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic clear_restart;
    logic clear_step;
    logic accept;
    logic decode;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic cfg_we;
    logic clear_done;
    logic is_lookup;
    logic issue_ok;
    logic last_issue;
  } status_t;

endpackage

FILE: hdl/fmt_ctrl.sv
module fmt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  fmt_pkg::status_t status_i,
  output fmt_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);

  fmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fmt_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) begin
          state_d = fmt_pkg::ST_IDLE;
        end
      end
      fmt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = fmt_pkg::ST_DECODE;
        end
      end
      fmt_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.is_lookup ? fmt_pkg::ST_RUN : fmt_pkg::ST_IDLE;
      end
      fmt_pkg::ST_RUN: begin
        if (status_i.issue_ok) begin
          cmd_o.issue = 1'b1;
          if (status_i.last_issue) begin
            state_d = fmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = fmt_pkg::ST_CLEAR;
      end
    endcase
    // register write restarts the clearing pass
    if (status_i.cfg_we) begin
      cmd_o               = '0;
      cmd_o.clear_restart = 1'b1;
      in_stall_o          = 1'b1;
      state_d             = fmt_pkg::ST_CLEAR;
    end
  end

endmodule

FILE: hdl/fmt_datapath.sv
module fmt_datapath #(
  parameter int unsigned MAX_LOGICAL      = fmt_pkg::MAX_LOGICAL_DEF,
  parameter int unsigned MAX_DESTINATIONS = fmt_pkg::MAX_DESTINATIONS_DEF,
  parameter int unsigned MAX_FANOUT       = fmt_pkg::MAX_FANOUT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [fmt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [fmt_pkg::FUNC_W-1:0]      func_i,
  input  logic [fmt_pkg::LI_W-1:0]        logical_index_i,
  input  logic [fmt_pkg::POS_W-1:0]       element_position_i,
  input  logic [fmt_pkg::PHYS_W-1:0]      physical_index_i,
  input  logic [fmt_pkg::CNT_W-1:0]       mapping_count_i,
  input  fmt_pkg::cmd_t                   cmd_i,
  output fmt_pkg::status_t                status_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [fmt_pkg::PHYS_W-1:0]      dest_index_o,
  output logic [fmt_pkg::CNT_W-1:0]       dest_count_o,
  output logic                            dest_valid_o,
  output logic                            run_last_o
);

  localparam int unsigned OFF_DEPTH = MAX_LOGICAL + 1;
  localparam int unsigned OAW       = $clog2(OFF_DEPTH);
  localparam int unsigned DAW       = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
  localparam int unsigned CLR_LEN   = (OFF_DEPTH > MAX_DESTINATIONS) ? OFF_DEPTH
                                                                     : MAX_DESTINATIONS;
  localparam int unsigned CW        = $clog2(CLR_LEN);
  localparam int unsigned LCW       = ($clog2(MAX_LOGICAL + 1) > fmt_pkg::LC_W)
                                      ? $clog2(MAX_LOGICAL + 1) : fmt_pkg::LC_W;
  localparam int unsigned TCW       = ($clog2(MAX_DESTINATIONS + 1) > fmt_pkg::TD_W)
                                      ? $clog2(MAX_DESTINATIONS + 1) : fmt_pkg::TD_W;
  localparam int unsigned LIW1      = fmt_pkg::LI_W + 1;

  logic [fmt_pkg::OFF_W-1:0]  off_mem  [OFF_DEPTH];
  logic [fmt_pkg::PHYS_W-1:0] dest_mem [MAX_DESTINATIONS];

  logic [fmt_pkg::LC_W-1:0]   logical_count_q;
  logic [fmt_pkg::TD_W-1:0]   total_dest_q;
  logic [CW-1:0]              clr_cnt_q;

  logic [fmt_pkg::FUNC_W-1:0] func_q;
  logic [fmt_pkg::LI_W-1:0]   li_q;
  logic [fmt_pkg::POS_W-1:0]  pos_q;
  logic [fmt_pkg::PHYS_W-1:0] phys_q;
  logic [fmt_pkg::CNT_W-1:0]  cnt_q;
  logic [fmt_pkg::OFF_W-1:0]  off_lo_q, off_hi_q;

  logic [fmt_pkg::OFF_W-1:0]  start_q;
  logic [fmt_pkg::CNT_W-1:0]  span_q, count_q, k_q;
  logic                       null_q;

  logic [fmt_pkg::PHYS_W-1:0] rd_data_q;
  logic                       rd_pend_q, pend_ok_q, pend_last_q;
  logic [fmt_pkg::CNT_W-1:0]  pend_cnt_q;

  logic                       out_valid_q, dest_valid_q, run_last_q;
  logic [fmt_pkg::PHYS_W-1:0] dest_index_q;
  logic [fmt_pkg::CNT_W-1:0]  dest_count_q;

  logic [LCW-1:0]             eff_logical;
  logic [TCW-1:0]             eff_total;
  logic [fmt_pkg::SLOT_W-1:0] total_ext, store_slot, run_slot;
  logic [LIW1-1:0]            li_inc, li_in_inc;
  logic [fmt_pkg::CNT_W-1:0]  cnt_sat, span_sat;
  logic [fmt_pkg::OFF_W-1:0]  close_data, span_diff;
  logic                       in_range, store_we, close_we, empty, slot_ok;
  logic                       load_out, clr_off, clr_dest;

  always_comb begin
    eff_logical = (LCW'(logical_count_q) > LCW'(MAX_LOGICAL)) ? LCW'(MAX_LOGICAL)
                                                              : LCW'(logical_count_q);
    eff_total   = (TCW'(total_dest_q) > TCW'(MAX_DESTINATIONS)) ? TCW'(MAX_DESTINATIONS)
                                                                : TCW'(total_dest_q);
    total_ext   = fmt_pkg::SLOT_W'(eff_total);
    in_range    = LCW'(li_q) < eff_logical;
    li_inc      = LIW1'(li_q) + LIW1'(1);
    li_in_inc   = LIW1'(logical_index_i) + LIW1'(1);

    store_slot  = fmt_pkg::SLOT_W'(off_lo_q) + fmt_pkg::SLOT_W'(pos_q);
    store_we    = cmd_i.decode && (func_q == fmt_pkg::FUNC_STORE) && in_range
                  && (store_slot < total_ext);

    cnt_sat     = (cnt_q > fmt_pkg::CNT_W'(MAX_FANOUT)) ? fmt_pkg::CNT_W'(MAX_FANOUT) : cnt_q;
    close_we    = cmd_i.decode && (func_q == fmt_pkg::FUNC_CLOSE) && in_range;
    close_data  = off_lo_q + fmt_pkg::OFF_W'(cnt_sat);

    empty       = !in_range || (off_hi_q <= off_lo_q);
    span_diff   = off_hi_q - off_lo_q;
    span_sat    = (span_diff > fmt_pkg::OFF_W'(MAX_FANOUT)) ? fmt_pkg::CNT_W'(MAX_FANOUT)
                                                            : span_diff[fmt_pkg::CNT_W-1:0];

    run_slot    = fmt_pkg::SLOT_W'(start_q) + fmt_pkg::SLOT_W'(k_q);
    slot_ok     = !null_q && (run_slot < total_ext);
    load_out    = rd_pend_q && (!out_valid_q || !out_stall_i);

    clr_off     = cmd_i.clear_step && ((CW + 1)'(clr_cnt_q) < (CW + 1)'(OFF_DEPTH));
    clr_dest    = cmd_i.clear_step && ((CW + 1)'(clr_cnt_q) < (CW + 1)'(MAX_DESTINATIONS));

    status_o.cfg_we     = cfg_valid_i;
    status_o.clear_done = clr_cnt_q == CW'(CLR_LEN - 1);
    status_o.is_lookup  = func_q == fmt_pkg::FUNC_LOOKUP;
    status_o.issue_ok   = !rd_pend_q || load_out;
    status_o.last_issue = (k_q + fmt_pkg::CNT_W'(1)) == span_q;
  end

  // config registers and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logical_count_q <= '0;
      total_dest_q    <= '0;
      clr_cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fmt_pkg::CFG_LOGICAL_COUNT: logical_count_q <= cfg_data_i[fmt_pkg::LC_W-1:0];
          fmt_pkg::CFG_TOTAL_DEST:    total_dest_q    <= cfg_data_i[fmt_pkg::TD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_restart) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clear_step && !status_o.clear_done) begin
        clr_cnt_q <= clr_cnt_q + CW'(1);
      end
    end
  end

  // offset store
  always_ff @(posedge clk_i) begin
    if (clr_off) begin
      off_mem[OAW'(clr_cnt_q)] <= '0;
    end else if (close_we) begin
      off_mem[OAW'(li_inc)] <= close_data;
    end
    if (cmd_i.accept) begin
      off_lo_q <= off_mem[OAW'(logical_index_i)];
      off_hi_q <= off_mem[OAW'(li_in_inc)];
    end
  end

  // destination store
  always_ff @(posedge clk_i) begin
    if (clr_dest) begin
      dest_mem[DAW'(clr_cnt_q)] <= '0;
    end else if (store_we) begin
      dest_mem[DAW'(store_slot)] <= phys_q;
    end
    if (cmd_i.issue) begin
      rd_data_q <= dest_mem[DAW'(run_slot)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      li_q   <= logical_index_i;
      pos_q  <= element_position_i;
      phys_q <= physical_index_i;
      cnt_q  <= mapping_count_i;
    end
    if (cmd_i.decode) begin
      start_q <= off_lo_q;
      span_q  <= empty ? fmt_pkg::CNT_W'(1) : span_sat;
      count_q <= empty ? '0 : span_sat;
      null_q  <= empty;
    end
    if (cmd_i.issue) begin
      pend_ok_q   <= slot_ok;
      pend_cnt_q  <= count_q;
      pend_last_q <= status_o.last_issue;
    end
    if (load_out) begin
      dest_index_q <= pend_ok_q ? rd_data_q : '0;
      dest_count_q <= pend_cnt_q;
      dest_valid_q <= pend_ok_q;
      run_last_q   <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        k_q <= '0;
      end else if (cmd_i.issue) begin
        k_q <= k_q + fmt_pkg::CNT_W'(1);
      end
      if (cmd_i.issue) begin
        rd_pend_q <= 1'b1;
      end else if (load_out) begin
        rd_pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_index_o = dest_index_q;
  assign dest_count_o = dest_count_q;
  assign dest_valid_o = dest_valid_q;
  assign run_last_o   = run_last_q;

endmodule

FILE: hdl/fanout_mapping_table.sv
// one-to-many mapping table: each logical entry owns a run of physical
// destinations, kept as an offset store plus a packed destination store
// input channel (in_valid_i / in_stall_o): one word per command, func_i
// selects store destination, close entry or lookup
// output channel (out_valid_o / out_stall_i): lookup words only, one per
// run element with dest_count_o and run_last_o; a bad index or empty run
// gives one word with dest_valid_o low and dest_count_o zero
// config channel (cfg_valid_i / cfg_ready_o): index 0 logical_count,
// index 1 total_destinations; cfg_ready_o is always high
// store and close read offsets on accept, then write memory in decode state
// lookup holds the input through accept, decode and one issue per output
// word (a bad index or empty run gives one word); the destination store
// read port gives one word per cycle unless the output stalls
// after reset and after every config write both stores are swept to zero
// over max(MAX_LOGICAL + 1, MAX_DESTINATIONS) addresses (8192 by default),
// with in_stall_o high; a config write during the sweep restarts it
// a stalled output word holds in the output register while the next word
// waits in the read stage; further reads pause until the output drains
module fanout_mapping_table #(
  parameter int unsigned MAX_LOGICAL      = fmt_pkg::MAX_LOGICAL_DEF,
  parameter int unsigned MAX_DESTINATIONS = fmt_pkg::MAX_DESTINATIONS_DEF,
  parameter int unsigned MAX_FANOUT       = fmt_pkg::MAX_FANOUT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fmt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fmt_pkg::FUNC_W-1:0]      func_i,
  input  logic [fmt_pkg::LI_W-1:0]        logical_index_i,
  input  logic [fmt_pkg::POS_W-1:0]       element_position_i,
  input  logic [fmt_pkg::PHYS_W-1:0]      physical_index_i,
  input  logic [fmt_pkg::CNT_W-1:0]       mapping_count_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fmt_pkg::PHYS_W-1:0]      dest_index_o,
  output logic [fmt_pkg::CNT_W-1:0]       dest_count_o,
  output logic                            dest_valid_o,
  output logic                            run_last_o
);

  fmt_pkg::cmd_t    cmd;
  fmt_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  fmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  fmt_datapath #(
    .MAX_LOGICAL      (MAX_LOGICAL),
    .MAX_DESTINATIONS (MAX_DESTINATIONS),
    .MAX_FANOUT       (MAX_FANOUT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .func_i             (func_i),
    .logical_index_i    (logical_index_i),
    .element_position_i (element_position_i),
    .physical_index_i   (physical_index_i),
    .mapping_count_i    (mapping_count_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .dest_index_o       (dest_index_o),
    .dest_count_o       (dest_count_o),
    .dest_valid_o       (dest_valid_o),
    .run_last_o         (run_last_o)
  );

endmodule

FILE: hdl/fmt_checker.sv
module fmt_checker #(
  parameter int unsigned MAX_FANOUT = fmt_pkg::MAX_FANOUT_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [fmt_pkg::PHYS_W-1:0]  dest_index_o,
  input logic [fmt_pkg::CNT_W-1:0]   dest_count_o,
  input logic                        dest_valid_o,
  input logic                        run_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dest_index_o)
      && $stable(dest_count_o) && $stable(dest_valid_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dest_valid_o |-> dest_index_o == '0)
    else $error("invalid word carries a nonzero destination");

  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dest_count_o == '0) |-> run_last_o && !dest_valid_o)
    else $error("empty lookup is not a single invalid word");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dest_count_o <= fmt_pkg::CNT_W'(MAX_FANOUT))
    else $error("run length above fanout limit");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input taken right after a config write");

endmodule

bind fanout_mapping_table fmt_checker #(
  .MAX_FANOUT (MAX_FANOUT)
) u_fmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .dest_index_o (dest_index_o),
  .dest_count_o (dest_count_o),
  .dest_valid_o (dest_valid_o),
  .run_last_o   (run_last_o)
);

FILE: bench/tb_fanout_mapping_table.sv
module tb_fanout_mapping_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LOGICAL = fmt_pkg::MAX_LOGICAL_DEF;
  localparam int unsigned MAX_DEST    = fmt_pkg::MAX_DESTINATIONS_DEF;
  localparam int unsigned MAX_FANOUT  = fmt_pkg::MAX_FANOUT_DEF;
  localparam logic [fmt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned RESET_ROWS = 5;
  localparam int unsigned N_ROWS = 23;
  localparam int unsigned N_PHASES = 6;

  typedef struct packed {
    logic [fmt_pkg::PHYS_W-1:0] idx;
    logic [fmt_pkg::CNT_W-1:0]  cnt;
    logic                       valid;
    logic                       last;
  } dest_word_t;

  typedef struct packed {
    logic [fmt_pkg::FUNC_W-1:0] func;
    logic [fmt_pkg::LI_W-1:0]   li;
    logic [fmt_pkg::POS_W-1:0]  pos;
    logic [fmt_pkg::PHYS_W-1:0] phys;
    logic [fmt_pkg::CNT_W-1:0]  cnt;
  } cmd_word_t;

  typedef struct packed {
    cmd_word_t w;
    logic      typed;
  } dir_row_t;

  typedef struct {
    logic [fmt_pkg::CFG_DATA_W-1:0] lc;
    logic [fmt_pkg::CFG_DATA_W-1:0] td;
    int unsigned                    snd;
    int unsigned                    rcv;
    int unsigned                    n;
  } phase_t;

  localparam dest_word_t NO_RUN = '{16'd0, 7'd0, 1'b0, 1'b1};

  // lookups marked typed expect the single invalid word
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd0,    6'd0,  16'h0000, 7'd0},   1'b1},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd4095, 6'd63, 16'hffff, 7'd127}, 1'b1},
    '{'{fmt_pkg::FUNC_STORE,  12'd0,    6'd0,  16'hffff, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd0,    6'd0,  16'h0000, 7'd64},  1'b0},
    '{'{FUNC_UNUSED,          12'd4095, 6'd63, 16'hffff, 7'd127}, 1'b0},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd0,    6'd0,  16'h0000, 7'd3},   1'b0},
    '{'{fmt_pkg::FUNC_STORE,  12'd0,    6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_STORE,  12'd0,    6'd1,  16'hffff, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_STORE,  12'd0,    6'd2,  16'h1234, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd0,    6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd1,    6'd0,  16'h0000, 7'd127}, 1'b0},
    '{'{fmt_pkg::FUNC_STORE,  12'd1,    6'd63, 16'ha5a5, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd1,    6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd4095, 6'd0,  16'h0000, 7'd0},   1'b1},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd4095, 6'd0,  16'h0000, 7'd64},  1'b0},
    '{'{fmt_pkg::FUNC_STORE,  12'd4095, 6'd63, 16'h5a5a, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd4095, 6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd1,    6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd1,    6'd0,  16'h0000, 7'd0},   1'b1},
    '{'{fmt_pkg::FUNC_CLOSE,  12'd0,    6'd0,  16'h0000, 7'd64},  1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd1,    6'd0,  16'h0000, 7'd0},   1'b1},
    '{'{FUNC_UNUSED,          12'd0,    6'd0,  16'h0000, 7'd0},   1'b0},
    '{'{fmt_pkg::FUNC_LOOKUP, 12'd0,    6'd0,  16'h0000, 7'd0},   1'b0}
  };

  phase_t phases [N_PHASES] = '{
    '{14'd16,    14'd64,    0,  0,  60},
    '{14'h3fff,  14'h3fff,  81, 0,  50},
    '{14'd10,    14'd20,    0,  81, 50},
    '{14'd3,     14'd5,     9,  9,  50},
    '{14'd0,     14'd0,     0,  0,  20},
    '{14'd4096,  14'd8192,  40, 40, 70}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [fmt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fmt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [fmt_pkg::FUNC_W-1:0]     func;
  logic [fmt_pkg::LI_W-1:0]       logical_index;
  logic [fmt_pkg::POS_W-1:0]      element_position;
  logic [fmt_pkg::PHYS_W-1:0]     physical_index;
  logic [fmt_pkg::CNT_W-1:0]      mapping_count;
  logic                           out_valid;
  logic                           out_stall;
  logic [fmt_pkg::PHYS_W-1:0]     dest_index;
  logic [fmt_pkg::CNT_W-1:0]      dest_count;
  logic                           dest_valid;
  logic                           run_last;

  // table copy and register copy
  logic [fmt_pkg::OFF_W-1:0]  offset_mem [0:MAX_LOGICAL];
  logic [fmt_pkg::PHYS_W-1:0] dest_mem [0:MAX_DEST-1];
  logic [fmt_pkg::LC_W-1:0]   lc_reg;
  logic [fmt_pkg::TD_W-1:0]   td_reg;

  dest_word_t  pending_dests_q [$];
  logic        typed_rows_q [$];
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned errors;
  int unsigned words_sent;
  int unsigned lookups_sent;
  int unsigned dests_checked;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;

  fanout_mapping_table i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .func_i             (func),
    .logical_index_i    (logical_index),
    .element_position_i (element_position),
    .physical_index_i   (physical_index),
    .mapping_count_i    (mapping_count),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .dest_index_o       (dest_index),
    .dest_count_o       (dest_count),
    .dest_valid_o       (dest_valid),
    .run_last_o         (run_last)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void clear_table();
    foreach (offset_mem[i]) offset_mem[i] = '0;
    foreach (dest_mem[i]) dest_mem[i] = '0;
  endfunction

  task automatic apply_table_word(input cmd_word_t w, input logic keep);
    int unsigned n_ent;
    int unsigned n_slot;
    int unsigned start;
    int unsigned span;
    int unsigned slot;
    int unsigned c;
    dest_word_t  d;
    n_ent  = (lc_reg > MAX_LOGICAL) ? MAX_LOGICAL : lc_reg;
    n_slot = (td_reg > MAX_DEST) ? MAX_DEST : td_reg;
    if (w.func == FUNC_UNUSED) return;
    if (w.func == fmt_pkg::FUNC_STORE || w.func == fmt_pkg::FUNC_CLOSE) begin
      if (w.li >= n_ent) return;
      start = (w.li == 0) ? 0 : offset_mem[w.li];
      if (w.func == fmt_pkg::FUNC_STORE) begin
        slot = start + w.pos;
        if (slot < n_slot) dest_mem[slot] = w.phys;
      end else begin
        c = (w.cnt > MAX_FANOUT) ? MAX_FANOUT : w.cnt;
        offset_mem[w.li] = start[fmt_pkg::OFF_W-1:0];
        offset_mem[w.li + 1] = fmt_pkg::OFF_W'(start + c);
      end
      return;
    end
    if (w.li >= n_ent || offset_mem[w.li + 1] <= offset_mem[w.li]) begin
      if (keep) pending_dests_q.push_back(NO_RUN);
      return;
    end
    start = offset_mem[w.li];
    span = offset_mem[w.li + 1] - start;
    if (span > MAX_FANOUT) span = MAX_FANOUT;
    for (int unsigned k = 0; k < span; k++) begin
      slot    = start + k;
      d.idx   = (slot < n_slot) ? dest_mem[slot] : '0;
      d.valid = (slot < n_slot);
      d.cnt   = span[fmt_pkg::CNT_W-1:0];
      d.last  = (k + 1 == span);
      if (keep) pending_dests_q.push_back(d);
    end
  endtask

  // monitor for all three channels
  always @(posedge clk_i) begin
    dest_word_t got;
    dest_word_t want;
    cmd_word_t  w;
    logic       typed;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fmt_pkg::CFG_LOGICAL_COUNT) lc_reg = cfg_data[fmt_pkg::LC_W-1:0];
        else td_reg = cfg_data[fmt_pkg::TD_W-1:0];
        clear_table();
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        w = '{func, logical_index, element_position, physical_index, mapping_count};
        typed = typed_rows_q.pop_front();
        apply_table_word(w, !typed);
        if (typed) pending_dests_q.push_back(NO_RUN);
        words_sent++;
        if (w.func == fmt_pkg::FUNC_LOOKUP) lookups_sent++;
      end
      if (out_valid && !out_stall) begin
        got = '{dest_index, dest_count, dest_valid, run_last};
        dests_checked++;
        if (pending_dests_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: idx %0d cnt %0d valid %0d last %0d",
                     got.idx, got.cnt, got.valid, got.last);
        end else begin
          want = pending_dests_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp idx %0d cnt %0d valid %0d last %0d,",
                        " got idx %0d cnt %0d valid %0d last %0d"},
                       want.idx, want.cnt, want.valid, want.last,
                       got.idx, got.cnt, got.valid, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_fanout_mapping_table: FAIL");
      $finish;
    end
  end

  task automatic send_word(input cmd_word_t w, input logic typed);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    typed_rows_q.push_back(typed);
    in_valid         <= 1'b1;
    func             <= w.func;
    logical_index    <= w.li;
    element_position <= w.pos;
    physical_index   <= w.phys;
    mapping_count    <= w.cnt;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_dests_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input fmt_pkg::cfg_reg_e idx,
                           input logic [fmt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [fmt_pkg::CFG_DATA_W-1:0] lc,
                            input logic [fmt_pkg::CFG_DATA_W-1:0] td);
    drain();
    write_reg(fmt_pkg::CFG_LOGICAL_COUNT, lc);
    write_reg(fmt_pkg::CFG_TOTAL_DEST, td);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_word_t random_word(input int unsigned n_ent);
    cmd_word_t   w;
    int unsigned li_hi;
    int unsigned r;
    w.phys = fmt_pkg::PHYS_W'($urandom);
    if ($urandom_range(99) < 75) begin
      li_hi = (n_ent == 0) ? 15 : ((n_ent - 1 < 15) ? n_ent - 1 : 15);
      w.li  = fmt_pkg::LI_W'($urandom_range(li_hi));
      if ($urandom_range(9) == 0) begin
        r = (n_ent == 0) ? 0 : n_ent - 1 + $urandom_range(1);
        w.li = fmt_pkg::LI_W'((r > 4095) ? 4095 : r);
      end
      r = $urandom_range(99);
      w.func = (r < 35) ? fmt_pkg::FUNC_STORE
                        : ((r < 60) ? fmt_pkg::FUNC_CLOSE : fmt_pkg::FUNC_LOOKUP);
      w.pos  = fmt_pkg::POS_W'(($urandom_range(99) < 85) ? $urandom_range(7) : $urandom);
      w.cnt  = fmt_pkg::CNT_W'(($urandom_range(99) < 85) ? $urandom_range(8)
                                                         : $urandom_range(127));
    end else begin
      w.func = fmt_pkg::FUNC_W'($urandom);
      w.li   = fmt_pkg::LI_W'($urandom);
      w.pos  = fmt_pkg::POS_W'($urandom);
      w.cnt  = fmt_pkg::CNT_W'($urandom);
    end
    return w;
  endfunction

  initial begin
    int unsigned n_ent;
    rst_ni           = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = fmt_pkg::CFG_LOGICAL_COUNT;
    cfg_data         = '0;
    in_valid         = 1'b0;
    func             = fmt_pkg::FUNC_STORE;
    logical_index    = '0;
    element_position = '0;
    physical_index   = '0;
    mapping_count    = '0;
    out_stall        = 1'b0;
    snd_idle         = 0;
    rcv_idle         = 0;
    errors           = 0;
    words_sent       = 0;
    lookups_sent     = 0;
    dests_checked    = 0;
    cfg_writes       = 0;
    quiet_cycles     = 0;
    lc_reg           = '0;
    td_reg           = '0;
    clear_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned k = 0; k < N_ROWS; k++) begin
      if (k == RESET_ROWS) set_config(14'd4096, 14'd8192);
      send_word(DIR_ROWS[k].w, DIR_ROWS[k].typed);
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      set_config(phases[p].lc, phases[p].td);
      snd_idle = phases[p].snd;
      rcv_idle = phases[p].rcv;
      n_ent = (lc_reg > MAX_LOGICAL) ? MAX_LOGICAL : lc_reg;
      for (int unsigned i = 0; i < phases[p].n; i++)
        send_word(random_word(n_ent), 1'b0);
    end

    drain();
    $display("run covered %0d command words (%0d lookups) over %0d register writes",
             words_sent, lookups_sent, cfg_writes);
    $display("%0d destination words checked, %0d errors", dests_checked, errors);
    if (errors == 0 && pending_dests_q.size() == 0) begin
      $display("tb_fanout_mapping_table: PASS");
    end else begin
      $display("tb_fanout_mapping_table: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fmt_pkg.sv
hdl/fmt_ctrl.sv
hdl/fmt_datapath.sv
hdl/fanout_mapping_table.sv
hdl/fmt_checker.sv
bench/tb_fanout_mapping_table.sv
